// ----- rtl/core/fau_pkg.sv -----
`default_nettype none
package fau_pkg;

  typedef enum logic [1:0] {
    CMD_MUL = 2'd0,
    CMD_DIV = 2'd1,
    CMD_ADD = 2'd2,
    CMD_SUB = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ZERO_DEN = 2'd1,
    ST_DIV_ZERO = 2'd2
  } status_t;

  localparam int unsigned NUM_W = 34;
  localparam int unsigned DEN_W = 32;
  localparam int unsigned OPW   = 64;

  typedef enum logic [4:0] {
    B_IDLE,
    B_MD_GCD,
    B_MD_DIVN,
    B_MD_DIVD,
    B_AS_G1,
    B_AS_RA,
    B_AS_CA,
    B_AS_G2,
    B_AS_RB,
    B_AS_CB,
    B_AS_GL,
    B_AS_DL,
    B_AS_ML,
    B_AS_QA,
    B_AS_QB,
    B_AS_TA,
    B_AS_TB,
    B_AS_FIN,
    B_DONE
  } bstate_t;

  typedef enum logic [1:0] {
    U_IDLE,
    U_DIV,
    U_MUL
  } ustate_t;

endpackage
`default_nettype wire

// ----- rtl/core/fau_divmul.sv -----
`default_nettype none
// Shared unit: restoring division (one quotient bit per cycle) and
// shift-and-add multiplication (one multiplier bit per cycle), 64 bits.
module fau_divmul
  import fau_pkg::*;
(
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start_div,
  input  wire logic           start_mul,
  input  wire logic [OPW-1:0] op_a,
  input  wire logic [OPW-1:0] op_b,
  output logic                busy,
  output logic                done,
  output logic [OPW-1:0]      quo,
  output logic [OPW-1:0]      rem,
  output logic [OPW-1:0]      prod
);

  ustate_t        st_r, st_nxt;
  logic [6:0]     cnt_r, cnt_nxt;
  logic [OPW-1:0] a_r, a_nxt;
  logic [OPW-1:0] b_r, b_nxt;
  logic [OPW-1:0] q_r, q_nxt;
  logic [OPW-1:0] rm_r, rm_nxt;
  logic [OPW+1:0] trial;
  logic           fin;

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      U_IDLE: begin
        if (start_div) st_nxt = U_DIV;
        else if (start_mul) st_nxt = U_MUL;
      end
      U_DIV:   if (fin) st_nxt = U_IDLE;
      U_MUL:   if (fin) st_nxt = U_IDLE;
      default: st_nxt = U_IDLE;
    endcase
  end

  assign fin   = (cnt_r == 7'(OPW - 1));
  assign trial = {1'b0, rm_r, a_r[OPW-1]} - {2'b00, b_r};

  always_comb begin
    cnt_nxt = cnt_r;
    a_nxt   = a_r;
    b_nxt   = b_r;
    q_nxt   = q_r;
    rm_nxt  = rm_r;
    case (st_r)
      U_IDLE: begin
        cnt_nxt = '0;
        a_nxt   = op_a;
        b_nxt   = op_b;
        q_nxt   = '0;
        rm_nxt  = '0;
      end
      U_DIV: begin
        cnt_nxt = cnt_r + 7'd1;
        a_nxt   = {a_r[OPW-2:0], 1'b0};
        if (!trial[OPW+1]) begin
          rm_nxt = trial[OPW-1:0];
          q_nxt  = {q_r[OPW-2:0], 1'b1};
        end else begin
          rm_nxt = {rm_r[OPW-2:0], a_r[OPW-1]};
          q_nxt  = {q_r[OPW-2:0], 1'b0};
        end
      end
      U_MUL: begin
        cnt_nxt = cnt_r + 7'd1;
        a_nxt   = {1'b0, a_r[OPW-1:1]};
        b_nxt   = {b_r[OPW-2:0], 1'b0};
        if (a_r[0]) q_nxt = q_r + b_r;
      end
      default: cnt_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= U_IDLE;
      done <= 1'b0;
    end else begin
      st_r <= st_nxt;
      done <= (st_r != U_IDLE) && fin;
    end
    cnt_r <= cnt_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    q_r   <= q_nxt;
    rm_r  <= rm_nxt;
  end

  assign busy = (st_r != U_IDLE);
  assign quo  = q_r;
  assign prod = q_r;
  assign rem  = rm_r;

endmodule
`default_nettype wire

// ----- rtl/core/fau_front.sv -----
`default_nettype none
// Front end: registers requests into a two-entry queue and classifies them.
module fau_front
  import fau_pkg::*;
#(
  parameter int unsigned IN_WIDTH = 16
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [1:0]          in_cmd,
  input  wire logic [IN_WIDTH-1:0] in_num_a,
  input  wire logic [IN_WIDTH-1:0] in_den_a,
  input  wire logic [IN_WIDTH-1:0] in_num_b,
  input  wire logic [IN_WIDTH-1:0] in_den_b,
  output logic                     q_valid,
  input  wire logic                q_take,
  output cmd_t                     q_cmd,
  output status_t                  q_status,
  output logic [OPW-1:0]           q_na,
  output logic [OPW-1:0]           q_da,
  output logic [OPW-1:0]           q_nb,
  output logic [OPW-1:0]           q_db
);

  localparam int unsigned EW = 2 + 2 + 4 * OPW;

  logic [EW-1:0] mem_r [2];
  logic [1:0]    cnt_r;
  logic          wp_r, rp_r;
  logic [EW-1:0] wdat;
  status_t       cls;
  logic          push, pop;

  always_comb begin
    if (in_den_a == '0 || in_den_b == '0) cls = ST_ZERO_DEN;
    else if (cmd_t'(in_cmd) == CMD_DIV && in_num_b == '0) cls = ST_DIV_ZERO;
    else cls = ST_OK;
  end

  assign wdat = {in_cmd, cls, OPW'(in_num_a), OPW'(in_den_a),
                 OPW'(in_num_b), OPW'(in_den_b)};
  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign pop      = q_take && q_valid;
  assign q_valid  = (cnt_r != 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
      if (push) wp_r <= !wp_r;
      if (pop) rp_r <= !rp_r;
    end
    if (push) mem_r[wp_r] <= wdat;
  end

  assign q_cmd    = cmd_t'(mem_r[rp_r][EW-1 -: 2]);
  assign q_status = status_t'(mem_r[rp_r][EW-3 -: 2]);
  assign q_na     = mem_r[rp_r][4*OPW-1 -: OPW];
  assign q_da     = mem_r[rp_r][3*OPW-1 -: OPW];
  assign q_nb     = mem_r[rp_r][2*OPW-1 -: OPW];
  assign q_db     = mem_r[rp_r][OPW-1 -: OPW];

endmodule
`default_nettype wire

// ----- rtl/core/fau_back.sv -----
`default_nettype none
// Back end: sequences the shared divide/multiply unit through each operation.
module fau_back
  import fau_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              q_valid,
  output logic                   q_take,
  input  wire cmd_t              q_cmd,
  input  wire status_t           q_status,
  input  wire logic [OPW-1:0]    q_na,
  input  wire logic [OPW-1:0]    q_da,
  input  wire logic [OPW-1:0]    q_nb,
  input  wire logic [OPW-1:0]    q_db,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic signed [NUM_W-1:0] out_res_num,
  output logic [DEN_W-1:0]       out_res_den,
  output logic [1:0]             out_status
);

  bstate_t        st_r, st_nxt;
  cmd_t           cmd_r;
  logic [OPW-1:0] x_r, y_r, p_r, q_r, ra_r, ca_r, rb_r, cb_r, l_r, ta_r, t_r;
  logic           ini_r;
  logic           start_div, start_mul, busy, done;
  logic [OPW-1:0] op_a, op_b, quo, rem, prod;
  logic           gcd_st;
  logic           out_free;
  logic [31:0]    mn_b, md_b;
  logic [OPW-1:0] mp_n, mp_d;

  fau_divmul u_dm (
    .clk       (clk),
    .rst_n     (rst_n),
    .start_div (start_div),
    .start_mul (start_mul),
    .op_a      (op_a),
    .op_b      (op_b),
    .busy      (busy),
    .done      (done),
    .quo       (quo),
    .rem       (rem),
    .prod      (prod)
  );

  assign out_free = !out_valid || !out_stall;
  assign gcd_st = (st_r == B_MD_GCD) || (st_r == B_AS_G1) || (st_r == B_AS_G2) ||
                  (st_r == B_AS_GL);

  assign mn_b = (q_cmd == CMD_MUL) ? q_nb[31:0] : q_db[31:0];
  assign md_b = (q_cmd == CMD_MUL) ? q_db[31:0] : q_nb[31:0];
  assign mp_n = {32'd0, q_na[31:0]} * {32'd0, mn_b};
  assign mp_d = {32'd0, q_da[31:0]} * {32'd0, md_b};

  // Unit steps issue one operation each, GCD steps one per remainder; ini_r marks the issue.
  always_comb begin
    start_div = 1'b0;
    start_mul = 1'b0;
    op_a      = x_r;
    op_b      = y_r;
    case (st_r)
      B_MD_GCD, B_AS_G1, B_AS_G2, B_AS_GL: start_div = !ini_r && (y_r != '0);
      B_MD_DIVN: begin op_a = p_r;  op_b = x_r;  start_div = !ini_r; end
      B_MD_DIVD: begin op_a = q_r;  op_b = x_r;  start_div = !ini_r; end
      B_AS_RA:   begin op_a = q_na; op_b = x_r;  start_div = !ini_r; end
      B_AS_CA:   begin op_a = q_da; op_b = x_r;  start_div = !ini_r; end
      B_AS_RB:   begin op_a = q_nb; op_b = x_r;  start_div = !ini_r; end
      B_AS_CB:   begin op_a = q_db; op_b = x_r;  start_div = !ini_r; end
      B_AS_DL:   begin op_a = ca_r; op_b = x_r;  start_div = !ini_r; end
      B_AS_ML:   begin op_a = t_r;  op_b = cb_r; start_mul = !ini_r; end
      B_AS_QA:   begin op_a = l_r;  op_b = ca_r; start_div = !ini_r; end
      B_AS_QB:   begin op_a = l_r;  op_b = cb_r; start_div = !ini_r; end
      B_AS_TA:   begin op_a = ra_r; op_b = t_r;  start_mul = !ini_r; end
      B_AS_TB:   begin op_a = rb_r; op_b = t_r;  start_mul = !ini_r; end
      default: begin
        start_div = 1'b0;
      end
    endcase
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      B_IDLE: begin
        if (q_valid) begin
          if (q_status != ST_OK) st_nxt = B_DONE;
          else if (q_cmd == CMD_MUL || q_cmd == CMD_DIV) st_nxt = B_MD_GCD;
          else st_nxt = B_AS_G1;
        end
      end
      B_MD_GCD:  if (!busy && y_r == '0) st_nxt = B_MD_DIVN;
      B_MD_DIVN: if (done) st_nxt = B_MD_DIVD;
      B_MD_DIVD: if (done) st_nxt = B_DONE;
      B_AS_G1:   if (!busy && y_r == '0) st_nxt = B_AS_RA;
      B_AS_RA:   if (done) st_nxt = B_AS_CA;
      B_AS_CA:   if (done) st_nxt = B_AS_G2;
      B_AS_G2:   if (!busy && y_r == '0) st_nxt = B_AS_RB;
      B_AS_RB:   if (done) st_nxt = B_AS_CB;
      B_AS_CB:   if (done) st_nxt = B_AS_GL;
      B_AS_GL:   if (!busy && y_r == '0) st_nxt = B_AS_DL;
      B_AS_DL:   if (done) st_nxt = B_AS_ML;
      B_AS_ML:   if (done) st_nxt = B_AS_QA;
      B_AS_QA:   if (done) st_nxt = B_AS_TA;
      B_AS_TA:   if (done) st_nxt = B_AS_QB;
      B_AS_QB:   if (done) st_nxt = B_AS_TB;
      B_AS_TB:   if (done) st_nxt = B_AS_FIN;
      B_AS_FIN:  st_nxt = B_DONE;
      B_DONE:    if (out_free) st_nxt = B_IDLE;
      default:   st_nxt = B_IDLE;
    endcase
  end

  // The request stays at the queue head until its result is registered.
  assign q_take = (st_r == B_DONE) && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= B_IDLE;
      ini_r     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (st_nxt != st_r) ini_r <= 1'b0;
      else if (start_div || start_mul) ini_r <= 1'b1;
      else if (gcd_st && done) ini_r <= 1'b0;
      if (st_r == B_DONE && out_free) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
    case (st_r)
      B_IDLE: begin
        cmd_r <= q_cmd;
        ra_r  <= '0;
        l_r   <= 64'd1;
        t_r   <= OPW'(q_status);
        if (q_status != ST_OK) begin
          p_r <= '0;
          q_r <= 64'd1;
        end else begin
          p_r <= mp_n;
          q_r <= mp_d;
        end
        if (q_cmd == CMD_MUL || q_cmd == CMD_DIV) begin
          x_r <= mp_n;
          y_r <= mp_d;
        end else begin
          x_r <= q_na;
          y_r <= q_da;
        end
      end
      B_MD_GCD, B_AS_G1, B_AS_G2, B_AS_GL: begin
        if (done) begin
          x_r <= y_r;
          y_r <= rem;
        end
      end
      B_MD_DIVN: if (done) p_r <= quo;
      B_MD_DIVD: if (done) begin
        q_r <= quo;
        t_r <= '0;
      end
      B_AS_RA: if (done) ra_r <= quo;
      B_AS_CA: if (done) begin
        ca_r <= quo;
        x_r  <= q_nb;
        y_r  <= q_db;
      end
      B_AS_RB: if (done) rb_r <= quo;
      B_AS_CB: if (done) begin
        cb_r <= quo;
        x_r  <= ca_r;
        y_r  <= quo;
      end
      B_AS_DL: if (done) t_r <= quo;
      B_AS_ML: if (done) l_r <= prod;
      B_AS_QA: if (done) t_r <= quo;
      B_AS_TA: if (done) ta_r <= prod;
      B_AS_QB: if (done) t_r <= quo;
      B_AS_TB: if (done) rb_r <= prod;
      B_AS_FIN: begin
        p_r <= (cmd_r == CMD_ADD) ? ta_r + rb_r : ta_r - rb_r;
        q_r <= l_r;
        t_r <= '0;
      end
      default: begin
        p_r <= p_r;
      end
    endcase
    if (st_r == B_DONE && out_free) begin
      out_res_num <= NUM_W'(p_r);
      out_res_den <= q_r[DEN_W-1:0];
      out_status  <= t_r[1:0];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/fraction_arithmetic_unit.sv -----
`default_nettype none
// Fraction arithmetic unit. Each request carries two unsigned fractions and an
// operation (multiply, divide, add, subtract) and yields one result fraction
// with a status. A front end holds up to two requests, the one in progress and
// one waiting; a back end runs each through one shared 64-bit unit that
// divides or multiplies one bit per cycle. Multiply and divide take the
// remainder steps of the Euclidean GCD plus two divisions; add and subtract
// take three GCDs and ten more unit operations; how long a request takes
// depends on the operands. A request with a zero denominator or a division by
// zero goes straight to its result without using the unit. Multiply and divide
// results are reduced; add and subtract results sit over the least common
// multiple and are not.
module fraction_arithmetic_unit
  import fau_pkg::*;
#(
  parameter int unsigned IN_WIDTH = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [1:0]           in_cmd,
  input  wire logic [IN_WIDTH-1:0]  in_num_a,
  input  wire logic [IN_WIDTH-1:0]  in_den_a,
  input  wire logic [IN_WIDTH-1:0]  in_num_b,
  input  wire logic [IN_WIDTH-1:0]  in_den_b,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic signed [NUM_W-1:0]   out_res_num,
  output logic [DEN_W-1:0]          out_res_den,
  output logic [1:0]                out_status
);

  logic           q_valid, q_take;
  cmd_t           q_cmd;
  status_t        q_status;
  logic [OPW-1:0] q_na, q_da, q_nb, q_db;

  fau_front #(.IN_WIDTH(IN_WIDTH)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_cmd   (in_cmd),
    .in_num_a (in_num_a),
    .in_den_a (in_den_a),
    .in_num_b (in_num_b),
    .in_den_b (in_den_b),
    .q_valid  (q_valid),
    .q_take   (q_take),
    .q_cmd    (q_cmd),
    .q_status (q_status),
    .q_na     (q_na),
    .q_da     (q_da),
    .q_nb     (q_nb),
    .q_db     (q_db)
  );

  fau_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid     (q_valid),
    .q_take      (q_take),
    .q_cmd       (q_cmd),
    .q_status    (q_status),
    .q_na        (q_na),
    .q_da        (q_da),
    .q_nb        (q_nb),
    .q_db        (q_db),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_res_num (out_res_num),
    .out_res_den (out_res_den),
    .out_status  (out_status)
  );

endmodule
`default_nettype wire

// ----- dv/testbench.sv -----
`default_nettype none
module testbench;
  import fau_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    cmd_t        cmd;
    logic [15:0] num_a;
    logic [15:0] den_a;
    logic [15:0] num_b;
    logic [15:0] den_b;
  } request_t;

  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
    status_t          status;
  } fraction_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_cmd = '0;
  logic [15:0] in_num_a = '0, in_den_a = '0, in_num_b = '0, in_den_b = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [NUM_W-1:0] out_res_num;
  logic [DEN_W-1:0] out_res_den;
  logic [1:0] out_status;

  request_t  pending_reqs[$];
  fraction_t expected_fracs[$];
  int  errors = 0;
  bit  stim_done = 0;
  bit  no_idle = 0;
  bit  in_taken = 0;
  int  in_gap = 0;
  int  out_gap = 0;

  fraction_arithmetic_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_cmd(in_cmd),
    .in_num_a(in_num_a), .in_den_a(in_den_a), .in_num_b(in_num_b), .in_den_b(in_den_b),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_res_num(out_res_num), .out_res_den(out_res_den), .out_status(out_status)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] gcd64(logic [63:0] x, logic [63:0] y);
    logic [63:0] t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  function automatic fraction_t compute_fraction(request_t r);
    fraction_t f;
    logic [63:0] na, da, nb, db, p, q, g, g1, g2, ra, ca, rb, cb, gl, l, ta, tb, rn, rd;
    na = r.num_a; da = r.den_a; nb = r.num_b; db = r.den_b;
    rn = 0; rd = 1;
    f.status = ST_OK;
    if (da == 0 || db == 0) begin
      f.status = ST_ZERO_DEN;
    end else if (r.cmd == CMD_DIV && nb == 0) begin
      f.status = ST_DIV_ZERO;
    end else if (r.cmd == CMD_MUL || r.cmd == CMD_DIV) begin
      p = (r.cmd == CMD_MUL) ? na * nb : na * db;
      q = (r.cmd == CMD_MUL) ? da * db : nb * da;
      g = gcd64(p, q);
      if (g != 0) begin
        rn = p / g;
        rd = q / g;
      end
    end else begin
      g1 = gcd64(na, da);
      g2 = gcd64(nb, db);
      ra = na / g1; ca = da / g1;
      rb = nb / g2; cb = db / g2;
      gl = gcd64(ca, cb);
      l = (ca / gl) * cb;
      ta = ra * (l / ca);
      tb = rb * (l / cb);
      rn = (r.cmd == CMD_ADD) ? ta + tb : ta - tb;
      rd = l;
    end
    f.num = rn[NUM_W-1:0];
    f.den = rd[DEN_W-1:0];
    return f;
  endfunction

  function automatic int pick_gap();
    if (no_idle) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(0, 2);
    return $urandom_range(10, 120);
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    errors++;
  endtask

  task automatic add_req(logic [1:0] c, logic [15:0] a, logic [15:0] b,
                         logic [15:0] x, logic [15:0] y);
    request_t r;
    r.cmd = cmd_t'(c);
    r.num_a = a; r.den_a = b; r.num_b = x; r.den_b = y;
    pending_reqs.push_back(r);
  endtask

  function automatic logic [15:0] rand_val(bit wide);
    if (wide) return 16'($urandom);
    return 16'($urandom_range(0, 255));
  endfunction

  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_taken) begin
        in_taken = 0;
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          request_t r;
          r = pending_reqs.pop_front();
          in_cmd <= r.cmd;
          in_num_a <= r.num_a; in_den_a <= r.den_a;
          in_num_b <= r.num_b; in_den_b <= r.den_b;
          in_valid <= 1'b1;
          in_gap = pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        out_gap = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        request_t r;
        r.cmd = cmd_t'(in_cmd);
        r.num_a = in_num_a; r.den_a = in_den_a; r.num_b = in_num_b; r.den_b = in_den_b;
        expected_fracs.push_back(compute_fraction(r));
        in_taken = 1;
      end
      if (out_valid && !out_stall) begin
        if (expected_fracs.size() == 0) begin
          report_mismatch("unexpected result", out_res_num, out_res_den);
        end else begin
          fraction_t e;
          e = expected_fracs.pop_front();
          if (out_res_num !== e.num) report_mismatch("res_num", out_res_num, e.num);
          if (out_res_den !== e.den) report_mismatch("res_den", out_res_den, e.den);
          if (out_status !== e.status) report_mismatch("status", out_status, e.status);
        end
      end
    end
  end

  initial begin
    int c;
    bit wide;
    logic [15:0] da, db;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    for (c = 0; c < 4; c++) begin
      add_req(2'(c), 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      add_req(2'(c), 16'hFFFF, 16'd1, 16'hFFFF, 16'd1);
      add_req(2'(c), 16'd1, 16'hFFFF, 16'd1, 16'hFFFE);
      add_req(2'(c), 16'd0, 16'd7, 16'd3, 16'd5);
      add_req(2'(c), 16'd3, 16'd0, 16'd3, 16'd5);
    end
    add_req(CMD_DIV, 16'd5, 16'd3, 16'd0, 16'd9);
    add_req(CMD_SUB, 16'd1, 16'hFFFF, 16'hFFFF, 16'd1);
    add_req(CMD_MUL, 16'd6, 16'd4, 16'd10, 16'd0);
    add_req(CMD_ADD, 16'd0, 16'd4, 16'd0, 16'd6);
    repeat (2000) begin
      c = $urandom_range(0, 3);
      wide = ($urandom_range(0, 9) < 2);
      da = rand_val(wide);
      db = rand_val(wide);
      if ($urandom_range(0, 19) != 0) begin
        if (da == 0) da = 1;
        if (db == 0) db = 1;
      end
      add_req(2'(c), ($urandom_range(0, 29) == 0) ? 16'd0 : rand_val(wide), da,
              ($urandom_range(0, 29) == 0) ? 16'd0 : rand_val(wide), db);
      if ($urandom_range(0, 299) == 0) no_idle = ~no_idle;
    end
    wait (pending_reqs.size() == 0 && !in_valid);
    wait (expected_fracs.size() == 0);
    repeat (5000) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #1000ms;
    $display("*** FAILED ***");
    $finish;
  end
endmodule
`default_nettype wire

// ----- files.f -----
rtl/core/fau_pkg.sv
rtl/core/fau_divmul.sv
rtl/core/fau_front.sv
rtl/core/fau_back.sv
rtl/core/fraction_arithmetic_unit.sv
dv/testbench.sv
